// File: rtl/natural_run_merge_sort_defines.svh
// Assertion macros for the natural run merge sorter.
// Used by the top level; no other dependencies.
`ifndef NATURAL_RUN_MERGE_SORT_DEFINES_SVH
`define NATURAL_RUN_MERGE_SORT_DEFINES_SVH
`ifndef SYNTH
`define NRMS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define NRMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define NRMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define NRMS_ASSERT_ALWAYS(label, clk, rst, cond)
`define NRMS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NRMS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/nrms_pkg.sv
// Shared constants and types for the natural run merge sorter.
// No dependencies.
package nrms_pkg;
   localparam int MAX_ITEMS = 1024;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int SEG_W     = CNT_W + 1;
   localparam int VALUE_W   = 32;
   localparam int TOTAL_W   = 11;

   typedef enum logic [1:0] {
      KIND_DONE     = 2'd0,
      KIND_VALUE    = 2'd1,
      KIND_PAST_END = 2'd2
   } kind_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_READ = 1'b1
   } command_type;
endpackage

// File: rtl/nrms_if.sv
// Request and response channel interfaces for the sorter.
// Depends on nrms_pkg.
interface nrms_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic signed [nrms_pkg::VALUE_W-1:0] value;
   logic                                last;
   modport source (output valid, command, value, last, input ready);
   modport sink   (input valid, command, value, last, output ready);
endinterface

interface nrms_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          kind;
   logic signed [nrms_pkg::VALUE_W-1:0] value_res;
   logic [nrms_pkg::TOTAL_W-1:0]        item_total;
   logic                                final_res;
   logic                                overflowed;
   modport source (output valid, kind, value_res, item_total, final_res, overflowed,
                   input ready);
   modport sink   (input valid, kind, value_res, item_total, final_res, overflowed,
                   output ready);
endinterface

// File: rtl/nrms_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module nrms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/natural_run_merge_sort.sv
// Top level of the natural run merge sorter: control FSM and two bank RAMs.
// Depends on nrms_pkg, nrms_if, nrms_ram and natural_run_merge_sort_defines.svh.
//
//  channel   dir  handshake        payload
//  req_chan  in   valid/ready      command, value, last
//  rsp_chan  out  valid/ready      kind, value_res, item_total, final_res, overflowed
//
// A load is written straight into the RAM; a read passes through ST_RDWAIT (RAM read register) to the response.
// A load marked last sorts in ceil(log2 n) merge passes: ST_MERGE and ST_FETCH per value, plus
// ST_SEG and ST_LOADL/ST_LOADR per run pair and ST_PASS per pass (single read port per bank).
// Synchronous active-high reset clears control state; the RAMs are not cleared.
// A new transaction is taken only when idle and the response register is empty.
`include "natural_run_merge_sort_defines.svh"
module natural_run_merge_sort (
   input logic        clock,
   input logic        reset,
   nrms_req_if.sink   req_chan,
   nrms_rsp_if.source rsp_chan
);
   localparam int IDX_W = nrms_pkg::IDX_W;
   localparam int CNT_W = nrms_pkg::CNT_W;
   localparam int SEG_W = nrms_pkg::SEG_W;
   localparam int VW    = nrms_pkg::VALUE_W;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_RDWAIT = 8'b0000_0010,
      ST_PASS   = 8'b0000_0100,
      ST_SEG    = 8'b0000_1000,
      ST_LOADL  = 8'b0001_0000,
      ST_LOADR  = 8'b0010_0000,
      ST_MERGE  = 8'b0100_0000,
      ST_FETCH  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, pos_ff, pos_in;
   logic              ovf_ff, ovf_in, bank_ff, bank_in;
   logic [SEG_W-1:0]  w_ff, w_in, s_ff, s_in, m_ff, m_in, e_ff, e_in, l_ff, l_in, r_ff, r_in;
   logic [IDX_W-1:0]  o_ff, o_in;
   logic              fetch_l_ff, fetch_l_in;
   logic signed [VW-1:0] hl_ff, hl_in, hr_ff, hr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic signed [VW-1:0] vres_ff, vres_in;
   logic [nrms_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic              fin_ff, fin_in, ovfo_ff, ovfo_in;

   // RAM ports
   logic              wr_en, wr_bank;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [VW-1:0]     wr_data, rd0, rd1, rd_data;

   logic              req_acc;
   logic [SEG_W-1:0]  n_seg, sw, s2w, l_nx, r_nx;
   logic              take_l;

   assign req_chan.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign rd_data        = bank_ff ? rd1 : rd0;
   assign n_seg          = SEG_W'(cnt_ff);
   assign sw             = s_ff + w_ff;
   assign s2w            = s_ff + (w_ff << 1);
   assign l_nx           = l_ff + 1'b1;
   assign r_nx           = r_ff + 1'b1;
   assign take_l = (l_ff < m_ff) && ((r_ff >= e_ff) || !(hr_ff < hl_ff));

   // Control and merge sequencing
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      bank_in      = bank_ff;
      w_in         = w_ff;
      s_in         = s_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      o_in         = o_ff;
      fetch_l_in   = fetch_l_ff;
      hl_in        = hl_ff;
      hr_in        = hr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      kind_in      = kind_ff;
      vres_in      = vres_ff;
      total_in     = total_ff;
      fin_in       = fin_ff;
      ovfo_in      = ovfo_ff;
      wr_en        = 1'b0;
      wr_bank      = bank_ff;
      wr_addr      = cnt_ff[IDX_W-1:0];
      wr_data      = req_chan.value;
      rd_addr      = pos_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.command == nrms_pkg::CMD_LOAD) begin
                  if (cnt_ff < CNT_W'(nrms_pkg::MAX_ITEMS)) begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_chan.last) begin
                     pos_in   = '0;
                     w_in     = SEG_W'(1);
                     state_in = ST_PASS;
                  end
               end else if (pos_ff < cnt_ff) begin
                  state_in = ST_RDWAIT;
               end else begin
                  rsp_valid_in = 1'b1;
                  kind_in      = nrms_pkg::KIND_PAST_END;
                  vres_in      = '0;
                  total_in     = '0;
                  fin_in       = 1'b0;
                  ovfo_in      = ovf_ff;
               end
            end
         end
         ST_RDWAIT: begin
            rsp_valid_in = 1'b1;
            kind_in      = nrms_pkg::KIND_VALUE;
            vres_in      = $signed(rd_data);
            total_in     = '0;
            fin_in       = (pos_ff + 1'b1) == cnt_ff;
            ovfo_in      = ovf_ff;
            pos_in       = pos_ff + 1'b1;
            state_in     = ST_IDLE;
         end
         ST_PASS: begin
            // one run left once the run width covers everything
            if (w_ff >= n_seg) begin
               rsp_valid_in = 1'b1;
               kind_in      = nrms_pkg::KIND_DONE;
               vres_in      = '0;
               total_in     = nrms_pkg::TOTAL_W'(cnt_ff);
               fin_in       = 1'b0;
               ovfo_in      = ovf_ff;
               state_in     = ST_IDLE;
            end else begin
               s_in     = '0;
               o_in     = '0;
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            m_in     = (sw < n_seg) ? sw : n_seg;
            e_in     = (s2w < n_seg) ? s2w : n_seg;
            l_in     = s_ff;
            r_in     = (sw < n_seg) ? sw : n_seg;
            rd_addr  = s_ff[IDX_W-1:0];
            state_in = ST_LOADL;
         end
         ST_LOADL: begin
            hl_in = $signed(rd_data);
            if (r_ff < e_ff) begin
               rd_addr  = r_ff[IDX_W-1:0];
               state_in = ST_LOADR;
            end else begin
               state_in = ST_MERGE;
            end
         end
         ST_LOADR: begin
            hr_in    = $signed(rd_data);
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            // emit the smaller head into the other bank
            wr_en   = 1'b1;
            wr_bank = !bank_ff;
            wr_addr = o_ff;
            wr_data = take_l ? hl_ff : hr_ff;
            o_in    = o_ff + 1'b1;
            if (take_l) begin
               l_in = l_nx;
            end else begin
               r_in = r_nx;
            end
            if (take_l && (l_nx < m_ff)) begin
               rd_addr    = l_nx[IDX_W-1:0];
               fetch_l_in = 1'b1;
               state_in   = ST_FETCH;
            end else if (!take_l && (r_nx < e_ff)) begin
               rd_addr    = r_nx[IDX_W-1:0];
               fetch_l_in = 1'b0;
               state_in   = ST_FETCH;
            end else if ((take_l && (r_ff < e_ff)) || (!take_l && (l_ff < m_ff))) begin
               state_in = ST_MERGE;
            end else begin
               // run pair finished
               s_in = e_ff;
               if (e_ff >= n_seg) begin
                  bank_in  = !bank_ff;
                  w_in     = w_ff << 1;
                  state_in = ST_PASS;
               end else begin
                  state_in = ST_SEG;
               end
            end
         end
         ST_FETCH: begin
            if (fetch_l_ff) begin
               hl_in = $signed(rd_data);
            end else begin
               hr_in = $signed(rd_data);
            end
            state_in = ST_MERGE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      w_ff       <= w_in;
      s_ff       <= s_in;
      m_ff       <= m_in;
      e_ff       <= e_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      o_ff       <= o_in;
      fetch_l_ff <= fetch_l_in;
      hl_ff      <= hl_in;
      hr_ff      <= hr_in;
      kind_ff    <= kind_in;
      vres_ff    <= vres_in;
      total_ff   <= total_in;
      fin_ff     <= fin_in;
      ovfo_ff    <= ovfo_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = kind_ff;
   assign rsp_chan.value_res  = vres_ff;
   assign rsp_chan.item_total = total_ff;
   assign rsp_chan.final_res  = fin_ff;
   assign rsp_chan.overflowed = ovfo_ff;

   // Bank RAMs: roles swap each pass; loads and reads use the bank_ff bank, merges write the other
   nrms_ram #(.WIDTH(VW), .DEPTH(nrms_pkg::MAX_ITEMS)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && !wr_bank),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd0)
   );

   nrms_ram #(.WIDTH(VW), .DEPTH(nrms_pkg::MAX_ITEMS)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && wr_bank),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd1)
   );

   // Checks
   `NRMS_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(nrms_pkg::MAX_ITEMS))
   `NRMS_ASSERT_IMPLY(a_busy_stall, clock, reset, state_ff != ST_IDLE, !req_chan.ready)
   `NRMS_ASSERT_IMPLY(a_merge_live, clock, reset, state_ff == ST_MERGE, (l_ff < m_ff) || (r_ff < e_ff))
   `NRMS_ASSERT_NEXT(a_read_resp, clock, reset, state_ff == ST_RDWAIT, rsp_chan.valid)
endmodule
